### src/qalt_pkg.sv
// Package for the quoted argument line tokenizer: widths, character codes,
// the tokenizer state and result word types. No dependencies.
package qalt_pkg;

  localparam int unsigned MaxArgs     = 8;
  localparam int unsigned BufferDepth = 256;

  localparam int unsigned HeadW = 9;   // holds 0 .. BufferDepth
  localparam int unsigned CntW  = 4;   // holds 0 .. MaxArgs
  localparam int unsigned AddrW = 8;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned LenW  = 9;

  localparam logic [7:0] ChrQuote = 8'h22;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrTab   = 8'h09;
  localparam logic [7:0] ChrCr    = 8'h0D;
  localparam logic [7:0] ChrLf    = 8'h0A;
  localparam logic [7:0] ChrNul   = 8'h00;

  localparam logic [LenW-1:0]  LenMin   = LenW'(2);
  localparam logic [LenW-1:0]  LenMax   = LenW'(BufferDepth);
  localparam logic [LenW-1:0]  LenReset = LenW'(BufferDepth);
  localparam logic [CntW-1:0]  CntMax   = CntW'(MaxArgs);

  typedef struct packed {
    logic [HeadW-1:0] head;
    logic [CntW-1:0]  cnt;
    logic [HeadW-1:0] arg_start;
    logic             in_quotes;
    logic             line_ready;
  } tok_state_t;

  typedef struct packed {
    logic             accepted;
    logic             write_valid;
    logic [AddrW-1:0] write_address;
    logic [7:0]       write_byte;
    logic             buffer_full;
    logic             arg_start_valid;
    logic [IdxW-1:0]  arg_index;
    logic [HeadW-1:0] arg_start_address;
    logic             line_done;
    logic [CntW-1:0]  arg_count;
  } tok_result_t;

endpackage

### src/qalt_step.sv
// Tokenizer step: next state and result word for one input word.
// Depends on qalt_pkg.
module qalt_step (
  input  logic                       action_i,
  input  logic [7:0]                 char_in_i,
  input  logic [qalt_pkg::LenW-1:0]  buffer_length_i,
  input  qalt_pkg::tok_state_t       state_i,
  output qalt_pkg::tok_state_t       state_o,
  output qalt_pkg::tok_result_t      result_o
);

  logic [qalt_pkg::LenW-1:0]  len;
  logic                       room;
  logic [qalt_pkg::HeadW-1:0] head_inc;
  logic [qalt_pkg::CntW-1:0]  cnt_inc;
  logic                       below_max;
  logic                       is_sep;
  logic                       inq_next;

  assign len = (buffer_length_i < qalt_pkg::LenMin) ? qalt_pkg::LenMin :
               (buffer_length_i > qalt_pkg::LenMax) ? qalt_pkg::LenMax : buffer_length_i;
  assign room      = state_i.head < len;
  assign head_inc  = qalt_pkg::HeadW'(state_i.head + qalt_pkg::HeadW'(1));
  assign cnt_inc   = qalt_pkg::CntW'(state_i.cnt + qalt_pkg::CntW'(1));
  assign below_max = state_i.cnt < qalt_pkg::CntMax;
  assign is_sep    = (char_in_i == qalt_pkg::ChrSpace) || (char_in_i == qalt_pkg::ChrTab);
  assign inq_next  = ~state_i.in_quotes;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    result_o.accepted = 1'b1;

    if (action_i) begin
      state_o = '0;
    end else if (state_i.line_ready) begin
      result_o.accepted = 1'b0;
    end else if (below_max && (char_in_i == qalt_pkg::ChrQuote)) begin
      state_o.in_quotes = inq_next;
      // closing quote always ends an argument, even an empty one
      if (!inq_next) begin
        state_o.cnt = cnt_inc;
        if (cnt_inc < qalt_pkg::CntMax) begin
          if (room) begin
            result_o.write_valid   = 1'b1;
            result_o.write_address = state_i.head[qalt_pkg::AddrW-1:0];
            result_o.write_byte    = qalt_pkg::ChrNul;
            state_o.head           = head_inc;
            state_o.arg_start      = head_inc;
            result_o.arg_start_address = head_inc;
          end else begin
            result_o.buffer_full       = 1'b1;
            state_o.arg_start          = state_i.head;
            result_o.arg_start_address = state_i.head;
          end
          result_o.arg_start_valid = 1'b1;
          result_o.arg_index       = cnt_inc[qalt_pkg::IdxW-1:0];
        end
      end
    end else if (below_max && !state_i.in_quotes && is_sep) begin
      // repeated separators are skipped
      if (state_i.arg_start != state_i.head) begin
        state_o.cnt = cnt_inc;
        if (cnt_inc < qalt_pkg::CntMax) begin
          if (room) begin
            result_o.write_valid   = 1'b1;
            result_o.write_address = state_i.head[qalt_pkg::AddrW-1:0];
            result_o.write_byte    = qalt_pkg::ChrNul;
            state_o.head           = head_inc;
            state_o.arg_start      = head_inc;
            result_o.arg_start_address = head_inc;
          end else begin
            result_o.buffer_full       = 1'b1;
            state_o.arg_start          = state_i.head;
            result_o.arg_start_address = state_i.head;
          end
          result_o.arg_start_valid = 1'b1;
          result_o.arg_index       = cnt_inc[qalt_pkg::IdxW-1:0];
        end else if (room) begin
          // last slot now open: separator kept as data
          result_o.write_valid   = 1'b1;
          result_o.write_address = state_i.head[qalt_pkg::AddrW-1:0];
          result_o.write_byte    = char_in_i;
          state_o.head           = head_inc;
        end else begin
          result_o.buffer_full = 1'b1;
        end
      end
    end else if (char_in_i == qalt_pkg::ChrCr) begin
      // terminator lands on the last byte when the buffer is full
      result_o.write_valid   = 1'b1;
      result_o.write_address = room ? state_i.head[qalt_pkg::AddrW-1:0]
                                    : qalt_pkg::AddrW'(len - qalt_pkg::LenW'(1));
      result_o.write_byte    = qalt_pkg::ChrNul;
      if (below_max && (state_i.arg_start < state_i.head)) begin
        state_o.cnt = cnt_inc;
      end
      state_o.head       = '0;
      state_o.in_quotes  = 1'b0;
      state_o.line_ready = 1'b1;
      result_o.line_done = 1'b1;
    end else if (char_in_i != qalt_pkg::ChrLf) begin
      if (room) begin
        result_o.write_valid   = 1'b1;
        result_o.write_address = state_i.head[qalt_pkg::AddrW-1:0];
        result_o.write_byte    = char_in_i;
        state_o.head           = head_inc;
      end else begin
        result_o.buffer_full = 1'b1;
      end
    end

    result_o.arg_count = state_o.cnt;
  end

endmodule

### src/qalt_out_reg.sv
// Result register between the tokenizer step and the output channel.
// Depends on qalt_pkg.
module qalt_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  qalt_pkg::tok_result_t result_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  can_load_o,
  output qalt_pkg::tok_result_t result_o
);

  logic                  valid_q, valid_d;
  qalt_pkg::tok_result_t data_q;

  // free when empty or when the held word leaves this cycle
  assign can_load_o = ~valid_q | out_ready_i;
  assign valid_d    = load_i | (valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

### src/quoted_argument_line_tokenizer.sv
// Top level of the quoted argument line tokenizer: state and length
// registers, step logic and result register. Depends on qalt_pkg,
// qalt_step and qalt_out_reg.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------
//  in       | in_valid_i/in_ready_o  | action_i, char_in_i
//  out      | out_valid_o/out_ready_i| accepted_o .. arg_count_o
//  cfg      | cfg_we_i               | cfg_wdata_i (buffer length)
//
// One word per cycle while in_ready_o is high; its result appears on the
// output in the cycle after acceptance, held in a single result register.
// in_ready_o drops only while that register is full and not being taken.
// Reset clears the tokenizer state and sets the buffer length to 256.
module quoted_argument_line_tokenizer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        action_i,
  input  logic [7:0]                  char_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        accepted_o,
  output logic                        write_valid_o,
  output logic [qalt_pkg::AddrW-1:0]  write_address_o,
  output logic [7:0]                  write_byte_o,
  output logic                        buffer_full_o,
  output logic                        arg_start_valid_o,
  output logic [qalt_pkg::IdxW-1:0]   arg_index_o,
  output logic [qalt_pkg::HeadW-1:0]  arg_start_address_o,
  output logic                        line_done_o,
  output logic [qalt_pkg::CntW-1:0]   arg_count_o,
  input  logic                        cfg_we_i,
  input  logic [qalt_pkg::LenW-1:0]   cfg_wdata_i
);

  qalt_pkg::tok_state_t      state_q, state_d;
  qalt_pkg::tok_result_t     step_res, out_res;
  logic [qalt_pkg::LenW-1:0] buf_len_q;
  logic                      can_load;
  logic                      take;

  assign in_ready_o = can_load;
  assign take       = in_valid_i & can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_len_q <= qalt_pkg::LenReset;
    end else if (cfg_we_i) begin
      buf_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (take) begin
      state_q <= state_d;
    end
  end

  qalt_step u_step (
    .action_i        (action_i),
    .char_in_i       (char_in_i),
    .buffer_length_i (buf_len_q),
    .state_i         (state_q),
    .state_o         (state_d),
    .result_o        (step_res)
  );

  qalt_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .result_i    (step_res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .can_load_o  (can_load),
    .result_o    (out_res)
  );

  assign accepted_o          = out_res.accepted;
  assign write_valid_o       = out_res.write_valid;
  assign write_address_o     = out_res.write_address;
  assign write_byte_o        = out_res.write_byte;
  assign buffer_full_o       = out_res.buffer_full;
  assign arg_start_valid_o   = out_res.arg_start_valid;
  assign arg_index_o         = out_res.arg_index;
  assign arg_start_address_o = out_res.arg_start_address;
  assign line_done_o         = out_res.line_done;
  assign arg_count_o         = out_res.arg_count;

endmodule
